[hw/rtl/imudr_pkg.sv]
// ----------------------------------------------------------------------------
// IMU dead-reckoning integrator package
// Shared types, codes, fixed-point constants and the rounding helper.
// ----------------------------------------------------------------------------
package imudr_pkg;

    // Multiplier operand and accumulator
    typedef logic signed [33:0] t_opnd;
    typedef logic signed [67:0] t_acc;

    // Item kinds
    localparam logic [1:0] KIND_START  = 2'd0;
    localparam logic [1:0] KIND_SAMPLE = 2'd1;
    localparam logic [1:0] KIND_FINISH = 2'd2;

    // Fixed-point constants; DT_DIFF_MAX is the largest gap whose scaled dt fits 32 bits
    localparam logic signed [33:0] ONE_Q30     = 34'sd1073741824;
    localparam logic signed [23:0] GRAV_RESET  = 24'sd642690;
    localparam logic signed [33:0] DT_SCALE    = 34'sd4295;
    localparam logic [47:0]        DT_DIFF_MAX = 48'd999992;
    localparam int unsigned        SD_STEPS    = 32;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_ROOT,
        ST_DIV
    } t_state;

    // Multiply-accumulate operations of one sample, in issue order
    typedef enum logic [4:0] {
        OP_DT,
        OP_H0, OP_H1, OP_H2,
        OP_SS,
        OP_Q0, OP_Q1, OP_Q2, OP_Q3,
        OP_R0, OP_R1, OP_R2, OP_R3, OP_R4, OP_R5, OP_R6, OP_R7, OP_R8,
        OP_A0, OP_A1, OP_A2,
        OP_V0, OP_V1, OP_V2,
        OP_P0, OP_D0, OP_P1, OP_D1, OP_P2, OP_D2
    } t_op;

    // Root / divide unit mode
    typedef enum logic {
        SD_SQRT,
        SD_DIV
    } t_sd_mode;

    typedef struct packed {
        logic     start;
        t_sd_mode mode;
    } t_sd_req;

    // MAC control travels with its product
    typedef struct packed {
        logic en;
        logic clr;
        logic sub;
    } t_mac_ctl;

    // Round v / 2^s to nearest, ties away from zero
    function automatic t_acc f_rshr(input t_acc v, input int unsigned s);
        logic [67:0] mag;
        mag = v[67] ? 68'(-v) : 68'(v);
        mag = (mag + (68'd1 << (s - 1))) >> s;
        return v[67] ? t_acc'(-mag) : t_acc'(mag);
    endfunction

endpackage

[hw/rtl/imudr_mac.sv]
// ----------------------------------------------------------------------------
// Shared multiply-accumulate unit
// Registered 34x34 signed product, then add or subtract into a 68-bit sum.
// ----------------------------------------------------------------------------
module imudr_mac (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  imudr_pkg::t_mac_ctl i_ctl,
    input  imudr_pkg::t_opnd   i_a,
    input  imudr_pkg::t_opnd   i_b,
    output imudr_pkg::t_acc    o_acc
);
    import imudr_pkg::*;

    t_mac_ctl r_ctl;
    t_acc     r_prod;
    t_acc     r_acc;

    // Delay control alongside the product
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    // Multiply, then accumulate
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
        if (r_ctl.en) begin
            r_acc <= (r_ctl.clr ? t_acc'(0) : r_acc) + (r_ctl.sub ? -r_prod : r_prod);
        end
    end

    assign o_acc = r_acc;

endmodule

[hw/rtl/imudr_sqdiv.sv]
// ----------------------------------------------------------------------------
// Iterative root / divide unit
// Shared compare-subtract: integer square root of 64 bits or a 64/32 divide
// with a 32-bit quotient, one result bit per cycle.
// ----------------------------------------------------------------------------
module imudr_sqdiv (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  imudr_pkg::t_sd_req i_req,
    input  logic [63:0]       i_num,
    input  logic [31:0]       i_den,
    output logic              o_busy,
    output logic              o_done,
    output logic [31:0]       o_res
);
    import imudr_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    t_sd_mode    r_mode;
    logic [33:0] r_rem;
    logic [63:0] r_src;
    logic [31:0] r_root;
    logic [31:0] r_den;

    logic [35:0] sh;
    logic [35:0] trial;
    logic [35:0] diff;
    logic        ge;

    // Bring down the next digit and try the subtract
    always_comb begin
        if (r_mode == SD_SQRT) begin
            sh    = {r_rem, r_src[63:62]};
            trial = {2'b00, r_root, 2'b01};
        end else begin
            sh    = {1'b0, r_rem, r_src[63]};
            trial = {4'b0000, r_den};
        end
        ge   = (sh >= trial);
        diff = sh - trial;
    end

    // Step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'(SD_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Load operands, then shift one result bit per step
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_mode <= i_req.mode;
            r_root <= '0;
            r_den  <= i_den;
            if (i_req.mode == SD_SQRT) begin
                r_rem <= '0;
                r_src <= i_num;
            end else begin
                r_rem <= {2'b00, i_num[63:32]};
                r_src <= {i_num[31:0], 32'd0};
            end
        end else if (r_busy) begin
            r_rem  <= ge ? diff[33:0] : sh[33:0];
            r_root <= {r_root[30:0], ge};
            r_src  <= (r_mode == SD_SQRT) ? {r_src[61:0], 2'b00} : {r_src[62:0], 1'b0};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_res  = r_root;

endmodule

[hw/rtl/imu_dead_reckoning_integrator_unit.sv]
// ----------------------------------------------------------------------------
// IMU dead-reckoning integrator
// Strapdown quaternion integration of IMU samples in fixed point.
// ----------------------------------------------------------------------------
// Start, finish and ignored items (kind three, or a sample not later than the
// last accepted time) are handled without leaving the idle state. A sample
// that advances time runs 30 multiply-accumulate operations on one shared
// 34x34 MAC; after the fifth (the sum of squares) an integer square root and
// four divides run on one bit-serial unit before the MAC operations resume.
// The input stalls during that time. A finish item copies the pose into an
// output register, so samples are taken while a result still waits; a second
// finish waits until the first result is taken. The user must write gravity_z
// only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module imu_dead_reckoning_integrator_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic signed [23:0] i_cfg_wr_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_kind,
    input  logic [47:0]        i_timestamp_us,
    input  logic signed [23:0] i_acc_x,
    input  logic signed [23:0] i_acc_y,
    input  logic signed [23:0] i_acc_z,
    input  logic signed [23:0] i_gyro_x,
    input  logic signed [23:0] i_gyro_y,
    input  logic signed [23:0] i_gyro_z,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_quat_w,
    output logic signed [31:0] o_quat_x,
    output logic signed [31:0] o_quat_y,
    output logic signed [31:0] o_quat_z,
    output logic signed [39:0] o_pos_x,
    output logic signed [39:0] o_pos_y,
    output logic signed [39:0] o_pos_z,
    output logic signed [31:0] o_vel_x,
    output logic signed [31:0] o_vel_y,
    output logic signed [31:0] o_vel_z
);
    import imudr_pkg::*;

    // Control state
    t_state r_state, n_state;
    t_op    r_op;
    logic [2:0] r_k;
    logic [1:0] r_di;
    logic       r_sd_go;
    logic       r_ovalid;

    // Pose state and configuration
    logic signed [23:0] r_grav;
    logic [47:0]        r_last;
    logic signed [31:0] r_q [4];
    logic signed [39:0] r_pos [3];
    logic signed [31:0] r_vel [3];

    // Per-sample working registers
    logic [47:0]        r_diff;
    logic [31:0]        r_dt;
    logic signed [23:0] r_acc_in [3];
    logic signed [23:0] r_gyro [3];
    logic signed [31:0] r_h [3];
    logic [63:0]        r_num;
    logic [31:0]        r_norm;
    logic signed [31:0] r_d [4];
    logic signed [31:0] r_qt [3];
    logic signed [32:0] r_rm [9];
    logic signed [29:0] r_aw [3];
    logic signed [29:0] r_dv [3];
    logic signed [32:0] r_tmp;

    // Output register
    logic signed [31:0] r_o_q [4];
    logic signed [39:0] r_o_pos [3];
    logic signed [31:0] r_o_vel [3];

    // Handshake
    logic in_acc;
    logic start_sample;
    logic ld_out;

    // MAC and root / divide connections
    t_mac_ctl    mac_ctl;
    t_opnd       mac_a, mac_b;
    t_acc        mac_acc;
    t_sd_req     sd_req;
    logic [63:0] sd_num;
    logic        sd_busy, sd_done;
    logic [31:0] sd_res;

    // Operand table of the current operation
    t_opnd      ta [4];
    t_opnd      tb [4];
    logic [3:0] tsub;
    logic [2:0] n_terms;
    logic       wb;
    t_opnd      dt_op;
    t_opnd      q1 [4];
    t_opnd      q2 [4];
    t_opnd      dd [4];

    // Operation indexes
    logic [1:0] ix_h, ix_q, ix_a, ix_v, ix_p;
    logic [3:0] ix_r;
    logic [1:0] hsel;
    logic [31:0] hmag;

    // Rounded accumulator values
    t_acc  rnd19, rnd30, rnd32, rnd33;
    logic signed [33:0] rdiag;
    logic signed [41:0] psum;
    logic signed [32:0] vsum;

    assign in_acc       = i_in_valid && !o_in_stall;
    assign start_sample = in_acc && (i_kind == KIND_SAMPLE) && (i_timestamp_us > r_last);
    assign ld_out       = in_acc && (i_kind == KIND_FINISH);
    assign o_in_stall   = (r_state != ST_IDLE) ||
                          (r_ovalid && i_out_stall && (i_kind == KIND_FINISH));

    assign ix_h = 2'(r_op - OP_H0);
    assign ix_q = 2'(r_op - OP_Q0);
    assign ix_r = 4'(r_op - OP_R0);
    assign ix_a = 2'(r_op - OP_A0);
    assign ix_v = 2'(r_op - OP_V0);
    assign ix_p = 2'((r_op - OP_P0) >> 1);
    assign hsel = (r_di == 2'd0) ? 2'd0 : r_di - 2'd1;
    assign hmag = r_h[hsel][31] ? 32'(-r_h[hsel]) : 32'(r_h[hsel]);

    // Operand shorthands
    always_comb begin
        dt_op = t_opnd'({2'b00, r_dt});
        for (int i = 0; i < 4; i++) begin
            q1[i] = 34'(r_q[i]);
            q2[i] = 34'(r_q[i]) <<< 1;
            dd[i] = 34'(r_d[i]);
        end
    end

    // Select terms for each operation
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            ta[i] = '0;
            tb[i] = '0;
        end
        tsub    = 4'b0000;
        n_terms = 3'd1;
        unique case (r_op)
            OP_DT: begin
                ta[0] = t_opnd'({14'd0, r_diff[19:0]});
                tb[0] = DT_SCALE;
            end
            OP_H0, OP_H1, OP_H2: begin
                ta[0] = 34'(r_gyro[ix_h]);
                tb[0] = dt_op;
            end
            OP_SS: begin
                n_terms = 3'd3;
                for (int i = 0; i < 3; i++) begin
                    ta[i] = 34'(r_h[i]);
                    tb[i] = 34'(r_h[i]);
                end
            end
            OP_Q0: begin
                n_terms = 3'd4;
                ta = '{q1[0], q1[1], q1[2], q1[3]};
                tb = '{dd[0], dd[1], dd[2], dd[3]};
                tsub = 4'b1110;
            end
            OP_Q1: begin
                n_terms = 3'd4;
                ta = '{q1[0], q1[1], q1[2], q1[3]};
                tb = '{dd[1], dd[0], dd[3], dd[2]};
                tsub = 4'b1000;
            end
            OP_Q2: begin
                n_terms = 3'd4;
                ta = '{q1[0], q1[1], q1[2], q1[3]};
                tb = '{dd[2], dd[3], dd[0], dd[1]};
                tsub = 4'b0010;
            end
            OP_Q3: begin
                n_terms = 3'd4;
                ta = '{q1[0], q1[1], q1[2], q1[3]};
                tb = '{dd[3], dd[2], dd[1], dd[0]};
                tsub = 4'b0100;
            end
            OP_R0: begin
                n_terms = 3'd2;
                ta[0] = q2[2]; tb[0] = q1[2]; ta[1] = q2[3]; tb[1] = q1[3];
            end
            OP_R1: begin
                n_terms = 3'd2;
                ta[0] = q2[1]; tb[0] = q1[2]; ta[1] = q2[0]; tb[1] = q1[3];
                tsub = 4'b0010;
            end
            OP_R2: begin
                n_terms = 3'd2;
                ta[0] = q2[1]; tb[0] = q1[3]; ta[1] = q2[0]; tb[1] = q1[2];
            end
            OP_R3: begin
                n_terms = 3'd2;
                ta[0] = q2[1]; tb[0] = q1[2]; ta[1] = q2[0]; tb[1] = q1[3];
            end
            OP_R4: begin
                n_terms = 3'd2;
                ta[0] = q2[1]; tb[0] = q1[1]; ta[1] = q2[3]; tb[1] = q1[3];
            end
            OP_R5: begin
                n_terms = 3'd2;
                ta[0] = q2[2]; tb[0] = q1[3]; ta[1] = q2[0]; tb[1] = q1[1];
                tsub = 4'b0010;
            end
            OP_R6: begin
                n_terms = 3'd2;
                ta[0] = q2[1]; tb[0] = q1[3]; ta[1] = q2[0]; tb[1] = q1[2];
                tsub = 4'b0010;
            end
            OP_R7: begin
                n_terms = 3'd2;
                ta[0] = q2[2]; tb[0] = q1[3]; ta[1] = q2[0]; tb[1] = q1[1];
            end
            OP_R8: begin
                n_terms = 3'd2;
                ta[0] = q2[1]; tb[0] = q1[1]; ta[1] = q2[2]; tb[1] = q1[2];
            end
            OP_A0, OP_A1, OP_A2: begin
                n_terms = 3'd3;
                for (int j = 0; j < 3; j++) begin
                    ta[j] = 34'(r_rm[4'(3 * ix_a + j)]);
                    tb[j] = 34'(r_acc_in[j]);
                end
            end
            OP_V0, OP_V1, OP_V2: begin
                ta[0] = 34'(r_aw[ix_v]);
                tb[0] = dt_op;
            end
            OP_P0, OP_P1, OP_P2: begin
                ta[0] = 34'(r_vel[ix_p]);
                tb[0] = dt_op;
            end
            OP_D0, OP_D1, OP_D2: begin
                ta[0] = 34'(r_dv[ix_p]);
                tb[0] = dt_op;
            end
            default: begin
                n_terms = 3'd1;
            end
        endcase
    end

    assign wb = (r_state == ST_MAC) && (r_k == n_terms + 3'd1);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (start_sample) n_state = ST_MAC;
            ST_MAC: begin
                if (wb && r_op == OP_SS) n_state = ST_ROOT;
                else if (wb && r_op == OP_D2) n_state = ST_IDLE;
            end
            ST_ROOT: if (sd_done) n_state = ST_DIV;
            ST_DIV:  if (sd_done && r_di == 2'd3) n_state = ST_MAC;
            default: n_state = ST_IDLE;
        endcase
    end

    // Unit controls
    always_comb begin
        mac_ctl.en  = (r_state == ST_MAC) && (r_k < n_terms);
        mac_ctl.clr = (r_k == 3'd0);
        mac_ctl.sub = tsub[r_k[1:0]];
        mac_a       = ta[r_k[1:0]];
        mac_b       = tb[r_k[1:0]];
        sd_req.start = r_sd_go;
        sd_req.mode  = (r_state == ST_ROOT) ? SD_SQRT : SD_DIV;
        if (r_state == ST_ROOT) begin
            sd_num = r_num;
        end else if (r_di == 2'd0) begin
            sd_num = (64'd1 << 60) + 64'(r_norm >> 1);
        end else begin
            sd_num = {2'b00, hmag, 30'd0} + 64'(r_norm >> 1);
        end
    end

    // Rounded values for write-back
    always_comb begin
        rnd19 = f_rshr(mac_acc, 19);
        rnd30 = f_rshr(mac_acc, 30);
        rnd32 = f_rshr(mac_acc, 32);
        rnd33 = f_rshr(mac_acc, 33);
        rdiag = ONE_Q30 - 34'(rnd30);
        psum  = 42'(r_pos[ix_p]) + 42'(r_tmp) + 42'(rnd33);
        vsum  = 33'(r_vel[ix_p]) + 33'(r_dv[ix_p]);
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_op     <= OP_DT;
            r_k      <= '0;
            r_di     <= '0;
            r_sd_go  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_sd_go  <= 1'b0;
            r_ovalid <= ld_out || (r_ovalid && i_out_stall);
            if (start_sample) begin
                r_op <= OP_DT;
                r_k  <= '0;
            end else if (wb) begin
                r_k <= '0;
                if (r_op != OP_D2) r_op <= t_op'(r_op + 1);
                if (r_op == OP_SS) r_sd_go <= 1'b1;
            end else if (r_state == ST_MAC) begin
                r_k <= r_k + 3'd1;
            end
            if (r_state == ST_ROOT && sd_done) begin
                r_di    <= '0;
                r_sd_go <= 1'b1;
            end
            if (r_state == ST_DIV && sd_done) begin
                r_di <= r_di + 2'd1;
                if (r_di != 2'd3) r_sd_go <= 1'b1;
            end
        end
    end

    // Pose state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grav <= GRAV_RESET;
            r_last <= '0;
            r_q    <= '{32'(ONE_Q30), 32'sd0, 32'sd0, 32'sd0};
            r_pos  <= '{default: '0};
            r_vel  <= '{default: '0};
        end else begin
            if (i_cfg_wr_en) r_grav <= i_cfg_wr_data;
            if (in_acc && i_kind == KIND_START) begin
                r_last <= i_timestamp_us;
                r_q    <= '{32'(ONE_Q30), 32'sd0, 32'sd0, 32'sd0};
                r_pos  <= '{default: '0};
                r_vel  <= '{default: '0};
            end
            if (start_sample) r_last <= i_timestamp_us;
            if (wb && r_op == OP_Q3) begin
                r_q[0] <= r_qt[0];
                r_q[1] <= r_qt[1];
                r_q[2] <= r_qt[2];
                if (rnd30 > 68'(ONE_Q30)) r_q[3] <= 32'(ONE_Q30);
                else if (rnd30 < -68'(ONE_Q30)) r_q[3] <= -32'(ONE_Q30);
                else r_q[3] <= rnd30[31:0];
            end
            // Integrate position with the old velocity, then velocity
            if (wb && (r_op == OP_D0 || r_op == OP_D1 || r_op == OP_D2)) begin
                if (psum > 42'sd549755813887) r_pos[ix_p] <= 40'sh7FFFFFFFFF;
                else if (psum < -42'sd549755813888) r_pos[ix_p] <= 40'sh8000000000;
                else r_pos[ix_p] <= psum[39:0];
                if (vsum > 33'sd2147483647) r_vel[ix_p] <= 32'sh7FFFFFFF;
                else if (vsum < -33'sd2147483648) r_vel[ix_p] <= 32'sh80000000;
                else r_vel[ix_p] <= vsum[31:0];
            end
        end
    end

    // Capture the sample and write back operation results
    always_ff @(posedge i_clk) begin
        if (start_sample) begin
            r_diff      <= i_timestamp_us - r_last;
            r_acc_in    <= '{i_acc_x, i_acc_y, i_acc_z};
            r_gyro      <= '{i_gyro_x, i_gyro_y, i_gyro_z};
        end
        if (r_state == ST_ROOT && sd_done) r_norm <= sd_res;
        if (r_state == ST_DIV && sd_done) begin
            if (r_di == 2'd0 || !r_h[hsel][31]) r_d[r_di] <= sd_res;
            else r_d[r_di] <= -sd_res;
        end
        if (wb) begin
            case (r_op)
                OP_DT: r_dt <= (r_diff > DT_DIFF_MAX) ? 32'hFFFFFFFF : mac_acc[31:0];
                OP_H0, OP_H1, OP_H2: begin
                    if (rnd19 > 68'sd2147483647) r_h[ix_h] <= 32'sh7FFFFFFF;
                    else if (rnd19 < -68'sd2147483648) r_h[ix_h] <= 32'sh80000000;
                    else r_h[ix_h] <= rnd19[31:0];
                end
                OP_SS: r_num <= mac_acc[63:0] + (64'd1 << 60);
                OP_Q0, OP_Q1, OP_Q2: begin
                    if (rnd30 > 68'(ONE_Q30)) r_qt[ix_q] <= 32'(ONE_Q30);
                    else if (rnd30 < -68'(ONE_Q30)) r_qt[ix_q] <= -32'(ONE_Q30);
                    else r_qt[ix_q] <= rnd30[31:0];
                end
                OP_R0, OP_R4, OP_R8: r_rm[ix_r] <= rdiag[32:0];
                OP_R1, OP_R2, OP_R3, OP_R5, OP_R6, OP_R7: r_rm[ix_r] <= rnd30[32:0];
                OP_A0, OP_A1: r_aw[ix_a] <= rnd30[29:0];
                OP_A2: r_aw[2] <= rnd30[29:0] - 30'(r_grav);
                OP_V0, OP_V1, OP_V2: r_dv[ix_v] <= rnd32[29:0];
                OP_P0, OP_P1, OP_P2: r_tmp <= rnd32[32:0];
                default: begin
                end
            endcase
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (ld_out) begin
            r_o_q   <= r_q;
            r_o_pos <= r_pos;
            r_o_vel <= r_vel;
        end
    end

    imudr_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .i_a     (mac_a),
        .i_b     (mac_b),
        .o_acc   (mac_acc)
    );

    imudr_sqdiv u_sqdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (sd_req),
        .i_num   (sd_num),
        .i_den   (r_norm),
        .o_busy  (sd_busy),
        .o_done  (sd_done),
        .o_res   (sd_res)
    );

    assign o_out_valid = r_ovalid;
    assign o_quat_w    = r_o_q[0];
    assign o_quat_x    = r_o_q[1];
    assign o_quat_y    = r_o_q[2];
    assign o_quat_z    = r_o_q[3];
    assign o_pos_x     = r_o_pos[0];
    assign o_pos_y     = r_o_pos[1];
    assign o_pos_z     = r_o_pos[2];
    assign o_vel_x     = r_o_vel[0];
    assign o_vel_y     = r_o_vel[1];
    assign o_vel_z     = r_o_vel[2];

    // Never restart the root / divide unit while it iterates
    a_sd_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sd_req.start |-> !sd_busy)
        else $error("root/divide unit restarted while busy");

    // A sample that advances time starts the MAC sequence
    a_sample_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start_sample |=> (r_state == ST_MAC && r_op == OP_DT && r_k == 3'd0))
        else $error("sample did not start the sequence");

    // Orientation stays within plus or minus one
    a_quat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_q[0] <= 32'sd1073741824 && r_q[0] >= -32'sd1073741824 &&
         r_q[1] <= 32'sd1073741824 && r_q[1] >= -32'sd1073741824 &&
         r_q[2] <= 32'sd1073741824 && r_q[2] >= -32'sd1073741824 &&
         r_q[3] <= 32'sd1073741824 && r_q[3] >= -32'sd1073741824))
        else $error("orientation component out of range");

endmodule
